[design/mwbm_pkg.sv]
// ----------------------------------------------------------------------------
// mwbm_pkg
// Shared widths, register codes and sequencer states of the point matcher.
// ----------------------------------------------------------------------------
package mwbm_pkg;

  localparam int MAX_POINTS  = 16;
  localparam int IDX_W       = $clog2(MAX_POINTS);
  localparam int CNT_W       = IDX_W + 1;
  localparam int COORD_W     = 16;
  localparam int POINT_W     = 2 * COORD_W;
  localparam int PT_AW       = IDX_W + 1;
  localparam int PT_DEPTH    = 2 * MAX_POINTS;
  localparam int WT_W        = 17;
  localparam int WT_AW       = 2 * IDX_W;
  localparam int WT_DEPTH    = MAX_POINTS * MAX_POINTS;
  localparam int LBL_W       = 20;
  localparam int GAP_W       = 21;
  localparam int TOT_W       = 21;
  localparam int SQ_W        = 32;
  localparam int ROOT_W      = 36;
  localparam int ROOT_ROUNDS = 18;
  localparam int RCNT_W      = 5;
  localparam int MAX_ROUNDS  = MAX_POINTS + 2;
  localparam int APB_AW      = 3;
  localparam int APB_DW      = 32;

  // register index, taken from paddr bit 2
  localparam logic REG_PREV_COUNT = 1'b0;
  localparam logic REG_CURR_COUNT = 1'b1;

  typedef enum logic [4:0] {
    S_LOAD,
    S_DIST_RD,
    S_DIST_RD2,
    S_DIST_MUL,
    S_DIST_SUM,
    S_DIST_ROOT,
    S_DIST_WR,
    S_LBL_RD,
    S_LBL_CMP,
    S_ROW_START,
    S_ROUND_START,
    S_SRCH_RD,
    S_SRCH_EV,
    S_AUG_WB,
    S_DELTA,
    S_RELABEL,
    S_TOT_RD,
    S_TOT_ADD,
    S_EMIT,
    S_ERR
  } state_t;

endpackage

[design/mwbm_if.sv]
// ----------------------------------------------------------------------------
// mwbm_if
// Valid/ready channels for point beats and result beats.
// ----------------------------------------------------------------------------
interface mwbm_in_if;
  import mwbm_pkg::*;
  logic               valid;
  logic               ready;
  logic               mode;
  logic [COORD_W-1:0] x_coord;
  logic [COORD_W-1:0] y_coord;
  modport source (output valid, mode, x_coord, y_coord, input ready);
  modport sink   (input valid, mode, x_coord, y_coord, output ready);
endinterface

interface mwbm_out_if;
  import mwbm_pkg::*;
  logic             valid;
  logic             ready;
  logic [IDX_W-1:0] curr_index;
  logic             matched;
  logic [IDX_W-1:0] prev_index;
  logic [TOT_W-1:0] total_weight;
  logic             error;
  logic             last;
  modport source (output valid, curr_index, matched, prev_index, total_weight, error, last,
                  input ready);
  modport sink   (input valid, curr_index, matched, prev_index, total_weight, error, last,
                  output ready);
endinterface

[design/mwbm_ram.sv]
// ----------------------------------------------------------------------------
// mwbm_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module mwbm_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rd_data_r;

  // write port and registered read port
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem_r[wr_addr] <= wr_data;
    end
    rd_data_r <= mem_r[rd_addr];
  end

  assign rd_data = rd_data_r;

endmodule

[design/max_weight_bipartite_matcher_top.sv]
// ----------------------------------------------------------------------------
// max_weight_bipartite_matcher_top
// Loads two point sets and finds the maximum-weight assignment between them.
// ----------------------------------------------------------------------------
// Usage: set prev_count and curr_count over the APB port (0 in the low five
// bits reads as 1, above 16 reads as 16, higher bits are ignored), then send
// point beats on in_ch, mode 0 for a previous point and mode 1 for a current
// point, in any interleaving. Points beyond a count are dropped. When both
// sets are full, in_ch drops ready and, unless prev_count exceeds curr_count,
// the block fills the 16x16 distance memory, each pair by two point reads,
// squaring, sum, 18 rounds of the bitwise root and a write. The label setup
// gives each previous point its row maximum as label. The augmenting search
// then walks a stack, each step bound by one read of the weight memory, with
// a scan of the current columns for each slack minimum and a relabel step.
// One result beat per current point follows on out_ch, or a single error
// beat when prev_count exceeds curr_count. Results leave through an output
// register, so a stalled receiver only holds the sequencer in its emit or
// error step; the next run's loading starts once the final beat is
// registered. Reset sets both counts to 1 and empties the loaders; the
// point, weight and label memories need no clearing.
// ----------------------------------------------------------------------------
module max_weight_bipartite_matcher_top (
  input  logic                          clk,
  input  logic                          rst_n,
  mwbm_in_if.sink                       in_ch,
  mwbm_out_if.source                    out_ch,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [mwbm_pkg::APB_AW-1:0]   paddr,
  input  logic [mwbm_pkg::APB_DW-1:0]   pwdata,
  output logic [mwbm_pkg::APB_DW-1:0]   prdata,
  output logic                          pready
);
  import mwbm_pkg::*;

  state_t state_r, state_nxt;

  logic [CNT_W-1:0] pc_r, cc_r, pc_m1, cc_m1;
  logic [CNT_W-1:0] prev_ld_r, curr_ld_r, prev_ld_nxt, curr_ld_nxt;
  logic             cfg_wr, in_acc, prev_wr, curr_wr, load_done;
  logic [CNT_W-1:0] cfg_val;

  logic [IDX_W-1:0] i_r, j_r, k_r, cur_r, cj_r;
  logic             i_last, j_last;
  logic [4:0]       round_r;
  logic [RCNT_W-1:0] rcnt_r;

  // point and weight memories
  logic [POINT_W-1:0] pt_rdata, prev_pt_r;
  logic [PT_AW-1:0]   pt_raddr, pt_waddr;
  logic               pt_wen;
  logic [WT_W-1:0]    wt_rdata;
  logic [WT_AW-1:0]   wt_raddr;
  logic               wt_wen;

  // distance datapath
  logic signed [COORD_W:0]     dx, dy;
  logic signed [2*COORD_W+1:0] px, py;
  logic [SQ_W-1:0]             sqx_r, sqy_r;
  logic [ROOT_W-1:0]           rv_r, res_r, bit_r, trial;

  // label, slack and search state
  logic signed [LBL_W-1:0] pl_r [MAX_POINTS];
  logic signed [LBL_W-1:0] cl_r [MAX_POINTS];
  logic signed [GAP_W-1:0] slack_r [MAX_POINTS];
  logic [MAX_POINTS-1:0]   sinf_r, vp_r, vc_r, pvalid_r;
  logic [IDX_W-1:0]        partner_r [MAX_POINTS];
  logic [IDX_W-1:0]        stk_row_r [MAX_POINTS];
  logic [CNT_W-1:0]        stk_next_r [MAX_POINTS];
  logic [IDX_W-1:0]        stk_pick_r [MAX_POINTS];
  logic [CNT_W-1:0]        sp_r;
  logic [IDX_W-1:0]        top, trow;
  logic [CNT_W-1:0]        tnext;
  logic [WT_W-1:0]         lmax_r, lmax_new;
  logic signed [GAP_W-1:0] gap, delta_r, delta_new;
  logic                    dinf_r, dinf_new, dcand;
  logic [TOT_W-1:0]        total_r;

  // result register
  logic             ov_r, slot_free;
  logic [IDX_W-1:0] o_curr_r, o_prev_r;
  logic             o_match_r, o_err_r, o_last_r;
  logic [TOT_W-1:0] o_total_r;

  // apb register port
  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite && pready;
  always_comb begin
    cfg_val = pwdata[CNT_W-1:0];
    if (cfg_val == '0) begin
      cfg_val = CNT_W'(1);
    end else if (cfg_val > CNT_W'(MAX_POINTS)) begin
      cfg_val = CNT_W'(MAX_POINTS);
    end
  end
  assign prdata = (paddr[2] == REG_CURR_COUNT) ? APB_DW'(cc_r) : APB_DW'(pc_r);

  // point loader
  assign in_ch.ready = (state_r == S_LOAD);
  assign in_acc      = in_ch.valid && in_ch.ready;
  assign prev_wr     = in_acc && !in_ch.mode && (prev_ld_r < pc_r);
  assign curr_wr     = in_acc && in_ch.mode && (curr_ld_r < cc_r);
  assign prev_ld_nxt = prev_ld_r + CNT_W'(prev_wr);
  assign curr_ld_nxt = curr_ld_r + CNT_W'(curr_wr);
  assign load_done   = (prev_wr || curr_wr) && (prev_ld_nxt == pc_r) && (curr_ld_nxt == cc_r);

  assign pc_m1  = pc_r - CNT_W'(1);
  assign cc_m1  = cc_r - CNT_W'(1);
  assign i_last = ({1'b0, i_r} == pc_m1);
  assign j_last = ({1'b0, j_r} == cc_m1);

  // stack top, or the write-back entry while committing a path
  assign top   = (state_r == S_AUG_WB) ? k_r : IDX_W'(sp_r - CNT_W'(1));
  assign trow  = stk_row_r[top];
  assign tnext = stk_next_r[top];

  // weight memory read address
  always_comb begin
    wt_raddr = {i_r, j_r};
    unique case (state_r)
      S_SRCH_RD: wt_raddr = {trow, tnext[IDX_W-1:0]};
      S_TOT_RD:  wt_raddr = {partner_r[j_r], j_r};
      default:   wt_raddr = {i_r, j_r};
    endcase
  end
  assign wt_wen = (state_r == S_DIST_WR);

  // point memory: previous points in the lower half, current in the upper
  assign pt_wen   = prev_wr || curr_wr;
  assign pt_waddr = curr_wr ? {1'b1, curr_ld_r[IDX_W-1:0]} : {1'b0, prev_ld_r[IDX_W-1:0]};
  assign pt_raddr = (state_r == S_DIST_RD) ? {1'b0, i_r} : {1'b1, j_r};

  mwbm_ram #(.WIDTH(POINT_W), .DEPTH(PT_DEPTH)) u_pt_ram (
    .clk(clk), .wr_en(pt_wen), .wr_addr(pt_waddr),
    .wr_data({in_ch.y_coord, in_ch.x_coord}), .rd_addr(pt_raddr), .rd_data(pt_rdata)
  );

  mwbm_ram #(.WIDTH(WT_W), .DEPTH(WT_DEPTH)) u_wt_ram (
    .clk(clk), .wr_en(wt_wen), .wr_addr({i_r, j_r}), .wr_data(res_r[WT_W-1:0]),
    .rd_addr(wt_raddr), .rd_data(wt_rdata)
  );

  // coordinate differences and squares
  assign dx = $signed({1'b0, prev_pt_r[COORD_W-1:0]}) - $signed({1'b0, pt_rdata[COORD_W-1:0]});
  assign dy = $signed({1'b0, prev_pt_r[POINT_W-1:COORD_W]})
            - $signed({1'b0, pt_rdata[POINT_W-1:COORD_W]});
  assign px = dx * dx;
  assign py = dy * dy;

  // one round of the bitwise square root
  assign trial = res_r + bit_r;

  // row maximum for the starting labels
  assign lmax_new = (j_r == '0 || wt_rdata > lmax_r) ? wt_rdata : lmax_r;

  // reduced cost of the edge under test
  assign gap = GAP_W'(pl_r[cur_r]) + GAP_W'(cl_r[cj_r]) - GAP_W'($signed({1'b0, wt_rdata}));

  // running slack minimum over unvisited columns
  assign dcand     = !vc_r[j_r] && !sinf_r[j_r] && (dinf_r || slack_r[j_r] < delta_r);
  assign delta_new = dcand ? slack_r[j_r] : delta_r;
  assign dinf_new  = dcand ? 1'b0 : dinf_r;

  assign slot_free = !ov_r || out_ch.ready;

  // state register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_LOAD;
    end else begin
      state_r <= state_nxt;
    end
  end

  // next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_LOAD: begin
        if (load_done) state_nxt = (pc_r > cc_r) ? S_ERR : S_DIST_RD;
      end
      S_DIST_RD:   state_nxt = S_DIST_RD2;
      S_DIST_RD2:  state_nxt = S_DIST_MUL;
      S_DIST_MUL:  state_nxt = S_DIST_SUM;
      S_DIST_SUM:  state_nxt = S_DIST_ROOT;
      S_DIST_ROOT: begin
        if (rcnt_r == RCNT_W'(ROOT_ROUNDS - 1)) state_nxt = S_DIST_WR;
      end
      S_DIST_WR: state_nxt = (i_last && j_last) ? S_LBL_RD : S_DIST_RD;
      S_LBL_RD:  state_nxt = S_LBL_CMP;
      S_LBL_CMP: state_nxt = (i_last && j_last) ? S_ROW_START : S_LBL_RD;
      S_ROW_START: state_nxt = S_ROUND_START;
      S_ROUND_START: begin
        if (round_r == 5'(MAX_ROUNDS)) state_nxt = i_last ? S_TOT_RD : S_ROW_START;
        else state_nxt = S_SRCH_RD;
      end
      S_SRCH_RD: begin
        if (sp_r == '0) state_nxt = S_DELTA;
        else if (tnext < cc_r && !vc_r[tnext[IDX_W-1:0]]) state_nxt = S_SRCH_EV;
      end
      S_SRCH_EV: state_nxt = (gap == '0 && !pvalid_r[cj_r]) ? S_AUG_WB : S_SRCH_RD;
      S_AUG_WB: begin
        if ({1'b0, k_r} == sp_r - CNT_W'(1)) state_nxt = i_last ? S_TOT_RD : S_ROW_START;
      end
      S_DELTA: begin
        if (j_last) begin
          if (dinf_new) state_nxt = i_last ? S_TOT_RD : S_ROW_START;
          else state_nxt = S_RELABEL;
        end
      end
      S_RELABEL: state_nxt = S_ROUND_START;
      S_TOT_RD:  state_nxt = S_TOT_ADD;
      S_TOT_ADD: state_nxt = j_last ? S_EMIT : S_TOT_RD;
      S_EMIT: begin
        if (slot_free && j_last) state_nxt = S_LOAD;
      end
      S_ERR: begin
        if (slot_free) state_nxt = S_LOAD;
      end
      default: state_nxt = S_LOAD;
    endcase
  end

  // control counters and flags
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pc_r      <= CNT_W'(1);
      cc_r      <= CNT_W'(1);
      prev_ld_r <= '0;
      curr_ld_r <= '0;
      i_r       <= '0;
      j_r       <= '0;
      k_r       <= '0;
      sp_r      <= '0;
      round_r   <= '0;
      rcnt_r    <= '0;
      vp_r      <= '0;
      vc_r      <= '0;
      pvalid_r  <= '0;
      sinf_r    <= '0;
      dinf_r    <= 1'b1;
      ov_r      <= 1'b0;
    end else begin
      // output register valid: set on a new beat, cleared when taken
      if ((state_r == S_EMIT || state_r == S_ERR) && slot_free) ov_r <= 1'b1;
      else if (out_ch.ready) ov_r <= 1'b0;
      if (cfg_wr) begin
        if (paddr[2] == REG_PREV_COUNT) pc_r <= cfg_val;
        else cc_r <= cfg_val;
        prev_ld_r <= '0;
        curr_ld_r <= '0;
      end else if (state_r == S_LOAD) begin
        prev_ld_r <= load_done ? '0 : prev_ld_nxt;
        curr_ld_r <= load_done ? '0 : curr_ld_nxt;
        i_r       <= '0;
        j_r       <= '0;
      end
      unique case (state_r)
        S_DIST_SUM:  rcnt_r <= '0;
        S_DIST_ROOT: rcnt_r <= rcnt_r + RCNT_W'(1);
        S_DIST_WR, S_LBL_CMP: begin
          j_r <= j_last ? '0 : j_r + IDX_W'(1);
          if (j_last) i_r <= i_last ? '0 : i_r + IDX_W'(1);
          if (state_r == S_DIST_WR && i_last && j_last) pvalid_r <= '0;
        end
        S_ROW_START: begin
          sinf_r  <= '1;
          round_r <= '0;
        end
        S_ROUND_START: begin
          if (round_r == 5'(MAX_ROUNDS)) begin
            i_r <= i_last ? '0 : i_r + IDX_W'(1);
            j_r <= '0;
          end else begin
            vc_r       <= '0;
            vp_r       <= MAX_POINTS'(1) << i_r;
            sp_r       <= CNT_W'(1);
          end
        end
        S_SRCH_RD: begin
          if (sp_r == '0) begin
            j_r    <= '0;
            dinf_r <= 1'b1;
          end else if (tnext >= cc_r) begin
            sp_r <= sp_r - CNT_W'(1);
          end
        end
        S_SRCH_EV: begin
          if (gap == '0) begin
            vc_r[cj_r] <= 1'b1;
            k_r        <= '0;
            if (pvalid_r[cj_r] && sp_r < CNT_W'(MAX_POINTS)) begin
              vp_r[partner_r[cj_r]] <= 1'b1;
              sp_r <= sp_r + CNT_W'(1);
            end
          end else if (sinf_r[cj_r] || slack_r[cj_r] > gap) begin
            sinf_r[cj_r] <= 1'b0;
          end
        end
        S_AUG_WB: begin
          pvalid_r[stk_pick_r[k_r]] <= 1'b1;
          k_r <= k_r + IDX_W'(1);
          if ({1'b0, k_r} == sp_r - CNT_W'(1)) begin
            i_r <= i_last ? '0 : i_r + IDX_W'(1);
            j_r <= '0;
          end
        end
        S_DELTA: begin
          dinf_r <= dinf_new;
          j_r    <= j_last ? '0 : j_r + IDX_W'(1);
          if (j_last && dinf_new) i_r <= i_last ? '0 : i_r + IDX_W'(1);
        end
        S_RELABEL: round_r <= round_r + 5'd1;
        S_TOT_ADD: j_r <= j_last ? '0 : j_r + IDX_W'(1);
        S_EMIT: begin
          if (slot_free) begin
            j_r  <= j_last ? '0 : j_r + IDX_W'(1);
          end
        end
        default: ;
      endcase
    end
  end

  // datapath registers
  always_ff @(posedge clk) begin
    unique case (state_r)
      S_DIST_RD2: prev_pt_r <= pt_rdata;
      S_DIST_MUL: begin
        sqx_r <= px[SQ_W-1:0];
        sqy_r <= py[SQ_W-1:0];
      end
      S_DIST_SUM: begin
        rv_r  <= ROOT_W'(sqx_r) + ROOT_W'(sqy_r);
        res_r <= '0;
        bit_r <= ROOT_W'(1) << (2 * (ROOT_ROUNDS - 1));
      end
      S_DIST_ROOT: begin
        if (rv_r >= trial) begin
          rv_r  <= rv_r - trial;
          res_r <= (res_r >> 1) + bit_r;
        end else begin
          res_r <= res_r >> 1;
        end
        bit_r <= bit_r >> 2;
      end
      S_DIST_WR: begin
        if (i_last && j_last) begin
          for (int n = 0; n < MAX_POINTS; n++) begin
            cl_r[n]      <= '0;
            partner_r[n] <= '0;
          end
        end
      end
      S_LBL_CMP: begin
        lmax_r <= lmax_new;
        if (j_last) pl_r[i_r] <= LBL_W'($signed({1'b0, lmax_new}));
      end
      S_ROUND_START: begin
        stk_row_r[0]  <= i_r;
        stk_next_r[0] <= '0;
      end
      S_SRCH_RD: begin
        if (sp_r != '0 && tnext < cc_r) begin
          stk_next_r[top] <= tnext + CNT_W'(1);
          cur_r           <= trow;
          cj_r            <= tnext[IDX_W-1:0];
        end
      end
      S_SRCH_EV: begin
        if (gap == '0) begin
          stk_pick_r[top] <= cj_r;
          if (pvalid_r[cj_r] && sp_r < CNT_W'(MAX_POINTS)) begin
            stk_row_r[sp_r[IDX_W-1:0]]  <= partner_r[cj_r];
            stk_next_r[sp_r[IDX_W-1:0]] <= '0;
          end
        end else if (sinf_r[cj_r] || slack_r[cj_r] > gap) begin
          slack_r[cj_r] <= gap;
        end
      end
      S_AUG_WB: partner_r[stk_pick_r[k_r]] <= stk_row_r[k_r];
      S_DELTA:  delta_r <= delta_new;
      S_RELABEL: begin
        for (int n = 0; n < MAX_POINTS; n++) begin
          if (vp_r[n]) pl_r[n] <= pl_r[n] - LBL_W'(delta_r);
          if (vc_r[n]) cl_r[n] <= cl_r[n] + LBL_W'(delta_r);
          else if (!sinf_r[n]) slack_r[n] <= slack_r[n] - delta_r;
        end
      end
      S_TOT_RD: begin
        if (j_r == '0) total_r <= '0;
      end
      S_TOT_ADD: begin
        if (pvalid_r[j_r]) total_r <= total_r + TOT_W'(wt_rdata);
      end
      S_EMIT: begin
        if (slot_free) begin
          o_curr_r  <= j_r;
          o_match_r <= pvalid_r[j_r];
          o_prev_r  <= pvalid_r[j_r] ? partner_r[j_r] : '0;
          o_total_r <= total_r;
          o_err_r   <= 1'b0;
          o_last_r  <= j_last;
        end
      end
      S_ERR: begin
        if (slot_free) begin
          o_curr_r  <= '0;
          o_match_r <= 1'b0;
          o_prev_r  <= '0;
          o_total_r <= '0;
          o_err_r   <= 1'b1;
          o_last_r  <= 1'b1;
        end
      end
      default: ;
    endcase
  end

  // result channel
  assign out_ch.valid        = ov_r;
  assign out_ch.curr_index   = o_curr_r;
  assign out_ch.matched      = o_match_r;
  assign out_ch.prev_index   = o_prev_r;
  assign out_ch.total_weight = o_total_r;
  assign out_ch.error        = o_err_r;
  assign out_ch.last         = o_last_r;

  // checks
  a_sp_bound: assert property (@(posedge clk) disable iff (!rst_n)
    sp_r <= CNT_W'(MAX_POINTS))
    else $error("search stack pointer beyond depth");

  a_err_last: assert property (@(posedge clk) disable iff (!rst_n)
    ov_r && o_err_r |-> o_last_r)
    else $error("error beat without last");

  a_cfg_restart: assert property (@(posedge clk) disable iff (!rst_n)
    cfg_wr |=> prev_ld_r == '0 && curr_ld_r == '0)
    else $error("register write did not restart loading");

  a_relabel_finite: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == S_RELABEL |-> !dinf_r)
    else $error("relabel with no finite slack");

endmodule
